// ===== rtl/core/rrfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the radar report frame deframer: frame constants, header and
// footer byte sequences, and the structs passed between the core modules.
// No dependencies.
package rrfd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES = 23;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned SYNC_BYTES  = 4;

  localparam logic [CNT_W-1:0] CNT_SYNC = CNT_W'(SYNC_BYTES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES - 1);

  // Header F4 F3 F2 F1, footer F8 F7 F6 F5
  localparam logic [7:0] HDR_SEQ [SYNC_BYTES] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [7:0] FTR_SEQ [SYNC_BYTES] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

  // Decoded report of one good frame
  typedef struct packed {
    logic [7:0]  tgt_state;
    logic [15:0] moving_distance_cm;
    logic [7:0]  move_energy;
    logic [15:0] still_distance_cm;
    logic [7:0]  rest_energy;
    logic [15:0] detection_distance_cm;
    logic        moving_flag;
    logic        present_flag;
  } rrfd_report_t;

  // Tracker status toward the top level
  typedef struct packed {
    logic             hit;    // the byte on the input completes a good frame
    logic [CNT_W-1:0] count;  // bytes held in the window
  } rrfd_status_t;

endpackage

// ===== rtl/core/rrfd_rx_if.sv =====
`timescale 1ns / 1ps
// Byte input channel of the radar report frame deframer.
// No dependencies.
interface rrfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/rrfd_rpt_if.sv =====
`timescale 1ns / 1ps
// Report output channel of the radar report frame deframer.
// No dependencies.
interface rrfd_rpt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tgt_state;
  logic [15:0] moving_distance_cm;
  logic [7:0]  move_energy;
  logic [15:0] still_distance_cm;
  logic [7:0]  rest_energy;
  logic [15:0] detection_distance_cm;
  logic        moving_flag;
  logic        present_flag;

  modport source (
    output valid, input ready,
    output tgt_state, output moving_distance_cm, output move_energy,
    output still_distance_cm, output rest_energy, output detection_distance_cm,
    output moving_flag, output present_flag
  );
  modport sink (
    input valid, output ready,
    input tgt_state, input moving_distance_cm, input move_energy,
    input still_distance_cm, input rest_energy, input detection_distance_cm,
    input moving_flag, input present_flag
  );
endinterface

// ===== rtl/core/rrfd_cell.sv =====
`timescale 1ns / 1ps
// One byte cell of the deframer window shift chain.
// Depends on nothing but the clock; payload only, no reset.
module rrfd_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d,
  output logic [7:0] q
);

  logic [7:0] data;

  // Take the neighbor's byte on every accepted request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

// ===== rtl/core/rrfd_tracker.sv =====
`timescale 1ns / 1ps
// Fill count and frame check of the deframer: header sync, full-frame test
// and report decode from the cell chain taps. Depends on rrfd_pkg.
module rrfd_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           taps [rrfd_pkg::FRAME_BYTES],
  output rrfd_pkg::rrfd_status_t status,
  output rrfd_pkg::rrfd_report_t report
);
  import rrfd_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cnt_eff;
  logic             hdr_ok;
  logic             ftr_ok;
  logic             hit;

  // Out-of-range count behaves as empty
  assign cnt_eff = (count > CNT_FULL) ? '0 : count;

  // Window after this byte: position j is tap j+1, position 22 is rx_byte
  assign hdr_ok = (taps[1] == HDR_SEQ[0]) && (taps[2] == HDR_SEQ[1]) &&
                  (taps[3] == HDR_SEQ[2]) && (taps[4] == HDR_SEQ[3]);
  assign ftr_ok = (taps[20] == FTR_SEQ[0]) && (taps[21] == FTR_SEQ[1]) &&
                  (taps[22] == FTR_SEQ[2]) && (rx_byte == FTR_SEQ[3]);
  assign hit    = (cnt_eff == CNT_FULL) && hdr_ok && ftr_ok;

  // Next fill count
  always_comb begin
    if (cnt_eff < CNT_SYNC) begin
      count_next = (rx_byte == HDR_SEQ[cnt_eff[1:0]]) ? cnt_eff + 1'b1 : '0;
    end else if (cnt_eff < CNT_FULL) begin
      count_next = cnt_eff + 1'b1;
    end else begin
      count_next = hit ? '0 : CNT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      count <= count_next;
    end
  end

  // Report decode; frame byte j is tap j+1
  always_comb begin
    report.tgt_state             = taps[9];
    report.moving_distance_cm    = {taps[11], taps[10]};
    report.move_energy           = taps[12];
    report.still_distance_cm     = {taps[14], taps[13]};
    report.rest_energy           = taps[15];
    report.detection_distance_cm = {taps[17], taps[16]};
    report.moving_flag           = (taps[9] == 8'd1) || (taps[9] == 8'd3);
    report.present_flag          = (taps[9] != 8'd0);
  end

  assign status.hit   = hit;
  assign status.count = count;

endmodule

// ===== rtl/core/radar_report_frame_deframer.sv =====
`timescale 1ns / 1ps
// Top level of the radar report frame deframer: 23-cell byte shift chain,
// fill tracker and report output register. Depends on rrfd_pkg, rrfd_rx_if,
// rrfd_rpt_if, rrfd_cell and rrfd_tracker.
//
//   channel  dir  payload                                   request
//   rx       in   rx_byte                                   one received byte
//   rpt      out  tgt_state, distances, energies, flags     one good frame
//
// Takes one byte per cycle while rx.ready is high; a report is valid on the
// cycle after the byte that closes a good frame. The 23 shift cells and the
// frame compare all work in parallel within that cycle.
// Reset clears the fill count and the report valid flag; cell contents and report data stay.
// rx.ready drops only while a report waits and rpt.ready is low.
module radar_report_frame_deframer (
  input logic     clk,
  input logic     rst,
  rrfd_rx_if.sink rx,
  rrfd_rpt_if.source rpt
);
  import rrfd_pkg::*;

  logic         step;
  logic [7:0]   taps [FRAME_BYTES];
  rrfd_status_t status;
  rrfd_report_t report;
  rrfd_report_t rpt_data;
  logic         rpt_valid;

  // Accept a byte whenever the report register is free or draining
  assign rx.ready = !rpt_valid || rpt.ready;
  assign step     = rx.valid && rx.ready;

  // Window shift chain: cell k takes from cell k+1, the last from the input
  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    if (k == FRAME_BYTES - 1) begin : g_last
      rrfd_cell u_cell (.clk(clk), .shift_en(step), .d(rx.rx_byte), .q(taps[k]));
    end else begin : g_mid
      rrfd_cell u_cell (.clk(clk), .shift_en(step), .d(taps[k+1]), .q(taps[k]));
    end
  end

  rrfd_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx.rx_byte),
    .taps    (taps),
    .status  (status),
    .report  (report)
  );

  // Report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (step && status.hit) begin
      rpt_valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && status.hit) begin
      rpt_data <= report;
    end
  end

  assign rpt.valid                 = rpt_valid;
  assign rpt.tgt_state             = rpt_data.tgt_state;
  assign rpt.moving_distance_cm    = rpt_data.moving_distance_cm;
  assign rpt.move_energy           = rpt_data.move_energy;
  assign rpt.still_distance_cm     = rpt_data.still_distance_cm;
  assign rpt.rest_energy           = rpt_data.rest_energy;
  assign rpt.detection_distance_cm = rpt_data.detection_distance_cm;
  assign rpt.moving_flag           = rpt_data.moving_flag;
  assign rpt.present_flag          = rpt_data.present_flag;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_FULL)
    else $error("fill count beyond full window");

  a_hit_clears: assert property (@(posedge clk) disable iff (rst)
    (step && status.hit) |=> (status.count == '0) && rpt_valid)
    else $error("good frame did not clear count or raise report");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && !rpt.ready) |-> !rx.ready)
    else $error("byte taken while report stalled");

endmodule
